// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, ignored while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Concurrent check on the rising clock edge that also holds in reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

// ----- rtl/tec_pkg.sv -----
`timescale 1ns / 1ps
// Package for the text encoding classifier: class codes and byte constants.
// No dependencies; used by the core and its checker.
package tec_pkg;

    // Encoding class codes
    localparam logic [2:0] CLS_UTF8    = 3'd0;
    localparam logic [2:0] CLS_UTF16LE = 3'd1;
    localparam logic [2:0] CLS_UTF16BE = 3'd2;
    localparam logic [2:0] CLS_UTF8BOM = 3'd3;
    localparam logic [2:0] CLS_UNKNOWN = 3'd4;

    // Continuation counter codes
    localparam logic [1:0] CONT_NONE   = 2'd0;
    localparam logic [1:0] CONT_ONE    = 2'd1;
    localparam logic [1:0] CONT_TWO    = 2'd2;
    localparam logic [1:0] CONT_BROKEN = 2'd3;

    // Byte-order marks
    localparam logic [15:0] BOM_UTF16LE  = 16'hFFFE;
    localparam logic [15:0] BOM_UTF16BE  = 16'hFEFF;
    localparam logic [15:0] BOM_UTF8_HEAD = 16'hEFBB;
    localparam logic [7:0]  BOM_UTF8_TAIL = 8'hBF;

    // Byte position saturates here
    localparam logic [1:0] POS_MAX = 2'd3;

endpackage

// ----- rtl/text_encoding_classifier_core.sv -----
`timescale 1ns / 1ps
// Text encoding classifier core; depends on tec_pkg.
// A byte is registered on acceptance, and the class of a text loads the result
// register when its last byte leaves the input register.
// Throughput: one byte per cycle; a final byte waits only while an untaken
// result is held. Reset (i_rst_n low, synchronous) empties both registers
// and clears all per-text state, so the next byte starts a new text.
module text_encoding_classifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_encoding_class
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_data;
    logic       r_last;

    // Per-text state
    logic [1:0]  r_pos;
    logic [15:0] r_lead;
    logic [1:0]  r_cont;
    logic        r_bad;

    // Result register
    logic       r_out_valid;
    logic [2:0] r_class;

    logic [1:0]  n_pos;
    logic [15:0] n_lead;
    logic [1:0]  n_cont;
    logic        n_bad;
    logic [2:0]  n_class;
    logic        w_fire;

    // Stage advances unless a final byte would overwrite an untaken result
    assign w_fire     = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    // UTF-8 sequence check
    always_comb begin
        n_cont = r_cont;
        n_bad  = r_bad;
        case (r_cont)
            tec_pkg::CONT_BROKEN: begin
                n_bad  = 1'b1;
                n_cont = tec_pkg::CONT_NONE;
            end
            tec_pkg::CONT_ONE, tec_pkg::CONT_TWO: begin
                if (r_data[7:6] == 2'b10) begin
                    n_cont = r_cont - 2'd1;
                end else if (r_cont == tec_pkg::CONT_TWO) begin
                    n_cont = tec_pkg::CONT_BROKEN;
                end else begin
                    n_bad  = 1'b1;
                    n_cont = tec_pkg::CONT_NONE;
                end
            end
            default: begin
                // No sequence open: classify by lead bits
                if (!r_data[7]) begin
                    n_cont = tec_pkg::CONT_NONE;
                end else if (!r_data[6]) begin
                    n_bad = 1'b1;
                end else if (!r_data[5]) begin
                    n_cont = tec_pkg::CONT_ONE;
                end else if (!r_data[4]) begin
                    n_cont = tec_pkg::CONT_TWO;
                end else begin
                    n_bad = 1'b1;
                end
            end
        endcase
    end

    // Leading byte capture for BOM detection
    always_comb begin
        n_lead = r_lead;
        case (r_pos)
            2'd0: n_lead = {r_data, 8'h00};
            2'd1: n_lead = {r_lead[15:8], r_data};
            2'd2: begin
                if (r_lead == tec_pkg::BOM_UTF8_HEAD && r_data != tec_pkg::BOM_UTF8_TAIL) begin
                    n_lead = 16'h0000;
                end
            end
            default: n_lead = r_lead;
        endcase
        n_pos = (r_pos == tec_pkg::POS_MAX) ? r_pos : r_pos + 2'd1;
    end

    // Final classification from the updated state
    always_comb begin
        if (n_pos[1] && n_lead == tec_pkg::BOM_UTF16LE) begin
            n_class = tec_pkg::CLS_UTF16LE;
        end else if (n_pos[1] && n_lead == tec_pkg::BOM_UTF16BE) begin
            n_class = tec_pkg::CLS_UTF16BE;
        end else if (n_pos == tec_pkg::POS_MAX && n_lead == tec_pkg::BOM_UTF8_HEAD) begin
            n_class = tec_pkg::CLS_UTF8BOM;
        end else if (n_bad) begin
            n_class = tec_pkg::CLS_UNKNOWN;
        end else begin
            n_class = tec_pkg::CLS_UTF8;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    // Per-text state; cleared after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_lead <= 16'h0000;
            r_cont <= tec_pkg::CONT_NONE;
            r_bad  <= 1'b0;
        end else if (w_fire) begin
            if (r_last) begin
                r_pos  <= 2'd0;
                r_lead <= 16'h0000;
                r_cont <= tec_pkg::CONT_NONE;
                r_bad  <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_lead <= n_lead;
                r_cont <= n_cont;
                r_bad  <= n_bad;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_last) begin
            r_class <= n_class;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_encoding_class = r_class;

endmodule

// ----- rtl/tec_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the text encoding classifier, bound to the core.
// Depends on assert_macros.svh and tec_pkg.
`include "assert_macros.svh"

module tec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_data_byte,
    input logic       i_last_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_encoding_class
);

    logic       w_in_wait;
    logic       w_out_wait;
    logic [8:0] w_in_word;
    logic       w_class_ok;

    // Channel stall conditions and the values they must hold
    assign w_in_wait  = i_in_valid && !o_in_ready;
    assign w_out_wait = o_out_valid && !i_out_ready;
    assign w_in_word  = {i_data_byte, i_last_byte};
    assign w_class_ok = (o_encoding_class <= tec_pkg::CLS_UNKNOWN);

    // A waiting input item holds its payload until taken
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, w_in_wait |=> i_in_valid && $stable(w_in_word))

    // A waiting result holds its value until taken
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, w_out_wait |=> o_out_valid && $stable(o_encoding_class))

    // Only defined class codes are shown
    `ASSERT_CLK(a_class_range, i_clk, i_rst_n, o_out_valid |-> w_class_ok)

    // With no result pending, the input side never stalls
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

    // Reset empties the result register
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind text_encoding_classifier_core tec_checker u_tec_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_data_byte      (i_data_byte),
    .i_last_byte      (i_last_byte),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_encoding_class (o_encoding_class)
);
